// ===== rtl/core/contiguous_ring_allocator_macros.svh =====
// Assertion helpers for the ring allocator. Bodies vanish under synthesis.
`ifndef CONTIGUOUS_RING_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_RING_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define CRA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ring allocator assertion failed");
// Check that cond never holds at a rising clock edge outside reset.
`define CRA_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ring allocator forbidden condition seen");
`else
`define CRA_ASSERT(label, clk, rst_n, prop)
`define CRA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/cra_pkg.sv =====
package cra_pkg;

	localparam int CAP_W = 17;
	localparam int OFS_W = 16;
	localparam int AMT_W = 17;
	localparam int ST_W  = 2;

	localparam logic [CAP_W-1:0] MAX_CAPACITY = 17'd65536;
	localparam logic [CAP_W-1:0] MIN_CAPACITY = 17'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_CONSUME = 1'b1;

	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_SPACE     = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_FIT       = 2'd2;
	localparam logic [ST_W-1:0] ST_OVER_CONSUME = 2'd3;

	typedef struct packed {
		logic             op;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [OFS_W-1:0] grant;
		logic [OFS_W-1:0] free_bytes;
		logic [OFS_W-1:0] used_bytes;
		logic [OFS_W-1:0] head_nxt;
		logic [OFS_W-1:0] tail_nxt;
	} step_res_t;

endpackage

// ===== rtl/core/contiguous_ring_allocator.sv =====
// Contiguous ring allocator: keeps head and tail offsets into a byte ring.
// Input stream (s_axis): one request per transfer. tuser selects the kind
// (allocate or consume), tdata carries the byte amount. Output stream
// (m_axis): one result per request, in request order. tuser is the status,
// tdata packs the granted offset and the free and used byte counts.
// Configuration: a pulse on cfg_we loads the ring capacity (clamped to
// 2..65536) and empties the ring; write it only with no request in flight.
// Pipeline: an accepted request is registered in the request stage,
// evaluated combinationally against the head and tail, and its result is
// registered in the output stage when that stage has room.
// Throughput: one request per cycle while the output is not stalled; the
// head/tail update is a single combinational add-compare-wrap path.
// Reset: capacity returns to 65536, head and tail to zero, both stages empty.
// Stall: a held result keeps the evaluation stage full; the input stays ready
// until that stage fills, then tready drops until the receiver takes the
// result.
module contiguous_ring_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cra_pkg::CAP_W-1:0] cfg_wdata,     // capacity in bytes
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,  // [16:0] amount, rest zero
	input  logic                      s_axis_tuser,  // [0] operation
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [47:0]               m_axis_tdata,  // [15:0] grant_offset,
	                                                 // [31:16] free_bytes,
	                                                 // [47:32] used_bytes
	output logic [cra_pkg::ST_W-1:0]  m_axis_tuser   // [1:0] status
);
	import cra_pkg::*;

`include "contiguous_ring_allocator_macros.svh"

	logic [CAP_W-1:0] capacity_q;
	logic [OFS_W-1:0] head_q, tail_q;
	logic             valid_s1;
	req_t             req_s1;
	logic             out_valid_q;
	step_res_t        res;
	step_res_t        out_q;
	logic             advance;
	logic [CAP_W-1:0] cap_clamped;

	// Move the registered request into the result register when it has room.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		cap_clamped = cfg_wdata;
		if (cfg_wdata < MIN_CAPACITY) begin
			cap_clamped = MIN_CAPACITY;
		end else if (cfg_wdata > MAX_CAPACITY) begin
			cap_clamped = MAX_CAPACITY;
		end
	end

	// Evaluate the registered request against the current ring state.
	cra_step u_step (
		.capacity (capacity_q),
		.head     (head_q),
		.tail     (tail_q),
		.req      (req_s1),
		.res      (res)
	);

	// Control state: stage valids and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= MAX_CAPACITY;
			head_q      <= '0;
			tail_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				// new capacity empties the ring
				capacity_q <= cap_clamped;
				head_q     <= '0;
				tail_q     <= '0;
			end else if (advance) begin
				head_q <= res.head_nxt;
				tail_q <= res.tail_nxt;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold while stalled, load on transfer.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.op     <= s_axis_tuser;
			req_s1.amount <= s_axis_tdata[AMT_W-1:0];
		end
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.used_bytes, out_q.free_bytes, out_q.grant};

	// Pointers never reach the capacity.
	`CRA_ASSERT(a_head_below_cap, clk, arst_n, {1'b0, head_q} < capacity_q)
	`CRA_ASSERT(a_tail_below_cap, clk, arst_n, {1'b0, tail_q} < capacity_q)
	// A failed request grants nothing.
	`CRA_ASSERT_NEVER(a_fail_no_grant, clk, arst_n, out_valid_q && (out_q.status != ST_OK) && (out_q.grant != '0))
	// A stalled evaluation stage keeps its request.
	`CRA_ASSERT(a_s1_holds, clk, arst_n, (valid_s1 && !advance) |=> valid_s1)

endmodule

// ===== rtl/core/cra_step.sv =====
module cra_step (
	input  logic [cra_pkg::CAP_W-1:0] capacity,
	input  logic [cra_pkg::OFS_W-1:0] head,
	input  logic [cra_pkg::OFS_W-1:0] tail,
	input  cra_pkg::req_t             req,
	output cra_pkg::step_res_t        res
);
	import cra_pkg::*;

	// occupied bytes between tail and head, modulo capacity
	function automatic logic [CAP_W-1:0] used_of(
		input logic [CAP_W-1:0] cap,
		input logic [CAP_W-1:0] h,
		input logic [CAP_W-1:0] t
	);
		if (h >= t) begin
			used_of = h - t;
		end else begin
			used_of = h + cap - t;
		end
	endfunction

	logic [CAP_W-1:0] h17, t17, used_cur, free_cur, room_end, head_sum, tail_sum;
	logic [CAP_W-1:0] used_new, free_new;
	logic [ST_W-1:0]  status;
	logic [OFS_W-1:0] grant, head_nxt, tail_nxt;

	assign h17      = {1'b0, head};
	assign t17      = {1'b0, tail};
	assign used_cur = used_of(capacity, h17, t17);
	assign free_cur = capacity - 17'd1 - used_cur;
	assign room_end = capacity - h17;
	assign head_sum = h17 + req.amount;
	assign tail_sum = t17 + req.amount;

	always_comb begin
		status   = ST_OK;
		grant    = '0;
		head_nxt = head;
		tail_nxt = tail;
		if (req.op == OP_ALLOC) begin
			if (free_cur < req.amount) begin
				status = ST_NO_SPACE;
			end else if (h17 >= t17) begin
				if (room_end >= req.amount) begin
					grant    = head;
					head_nxt = (head_sum >= capacity) ? '0 : head_sum[OFS_W-1:0];
				end else if (t17 > req.amount) begin
					// wrap to the start of the ring
					head_nxt = req.amount[OFS_W-1:0];
				end else begin
					status = ST_NO_FIT;
				end
			end else begin
				grant    = head;
				head_nxt = head_sum[OFS_W-1:0];
			end
		end else begin
			if (used_cur < req.amount) begin
				status = ST_OVER_CONSUME;
			end else if (tail_sum >= capacity) begin
				tail_nxt = tail_sum[OFS_W-1:0] - capacity[OFS_W-1:0];
			end else begin
				tail_nxt = tail_sum[OFS_W-1:0];
			end
		end
	end

	assign used_new = used_of(capacity, {1'b0, head_nxt}, {1'b0, tail_nxt});
	assign free_new = capacity - 17'd1 - used_new;

	assign res.status     = status;
	assign res.grant      = grant;
	assign res.free_bytes = free_new[OFS_W-1:0];
	assign res.used_bytes = used_new[OFS_W-1:0];
	assign res.head_nxt   = head_nxt;
	assign res.tail_nxt   = tail_nxt;

endmodule
